FILE: rtl/core/fsip_pkg.sv
// shared types and constants for the format string integer printer
`timescale 1ns / 1ps

package fsip_pkg;

    // fixed field widths
    localparam int CHAR_WIDTH  = 8;
    localparam int ARG_WIDTH   = 32;
    localparam int COLOR_WIDTH = 8;

    // character codes
    localparam logic [CHAR_WIDTH-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_WIDTH-1:0] CH_PCT   = 8'h25;
    localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_WIDTH-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_WIDTH-1:0] CH_LOW_A = 8'h61;
    localparam logic [CHAR_WIDTH-1:0] CH_CONV_C = 8'h63;
    localparam logic [CHAR_WIDTH-1:0] CH_CONV_D = 8'h64;
    localparam logic [CHAR_WIDTH-1:0] CH_CONV_O = 8'h6f;
    localparam logic [CHAR_WIDTH-1:0] CH_CONV_S = 8'h73;
    localparam logic [CHAR_WIDTH-1:0] CH_CONV_X = 8'h78;

    // color handling
    localparam logic [COLOR_WIDTH-1:0] BASE_COLOR_RESET = 8'd15;
    localparam logic [COLOR_WIDTH-1:0] COLOR_HI_MASK    = 8'hf0;

    // decimal digit limit used by the dabble adjust
    localparam logic [3:0] DEC_ADJ_LIMIT = 4'd5;
    localparam logic [3:0] DEC_ADJ_ADD   = 4'd3;
    localparam logic [3:0] DEC_RADIX     = 4'd10;

    // input beat
    typedef struct packed {
        logic [CHAR_WIDTH-1:0] fmt_char;
        logic [ARG_WIDTH-1:0]  arg_value;
    } t_in_item;

    // output beat
    typedef struct packed {
        logic [CHAR_WIDTH-1:0]  out_char;
        logic [COLOR_WIDTH-1:0] text_color;
        logic                   last_of_run;
    } t_out_item;

    // request into the number converter
    typedef struct packed {
        logic                 start;
        logic                 hex;
        logic [ARG_WIDTH-1:0] mag;
    } t_conv_req;

    // character offered by the number converter
    typedef struct packed {
        logic                  valid;
        logic [CHAR_WIDTH-1:0] ch;
        logic                  last;
    } t_conv_rsp;

    // one digit to its ascii character
    function automatic logic [CHAR_WIDTH-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_WIDTH-1:0] res;
        if (d < DEC_RADIX) begin
            res = CH_ZERO + {4'h0, d};
        end else begin
            res = CH_LOW_A + {4'h0, d - DEC_RADIX};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/fsip_conv.sv
// bit-serial number converter: double dabble for decimal, nibble shift-out for hex
`timescale 1ns / 1ps

module fsip_conv #(
    parameter int DIGITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fsip_pkg::t_conv_req i_req,
    input  logic                i_take,
    output fsip_pkg::t_conv_rsp o_rsp
);

    localparam int DW = DIGITS * 4;
    localparam int CW = $clog2(DIGITS + 1);
    localparam int BW = $clog2(fsip_pkg::ARG_WIDTH + 1);

    typedef enum logic [2:0] {
        C_IDLE  = 3'b001,
        C_DAB   = 3'b010,
        C_EMIT  = 3'b100
    } t_cstate;

    t_cstate                          r_state, n_state;
    logic [DW-1:0]                    r_dig, n_dig;
    logic [fsip_pkg::ARG_WIDTH-1:0]   r_bin, n_bin;
    logic [BW-1:0]                    r_bits, n_bits;
    logic [CW-1:0]                    r_left, n_left;
    logic                             r_lead, n_lead;
    logic [DW-1:0]                    adj;
    logic [3:0]                       top;
    logic                             skip;

    // add-3 adjust on every digit lane
    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (r_dig[k*4 +: 4] >= fsip_pkg::DEC_ADJ_LIMIT) begin
                adj[k*4 +: 4] = r_dig[k*4 +: 4] + fsip_pkg::DEC_ADJ_ADD;
            end else begin
                adj[k*4 +: 4] = r_dig[k*4 +: 4];
            end
        end
    end

    // leading digit and zero suppression
    assign top  = r_dig[DW-1 -: 4];
    assign skip = r_lead && (top == 4'h0) && (r_left != CW'(1));

    assign o_rsp.valid = (r_state == C_EMIT) && !skip;
    assign o_rsp.ch    = fsip_pkg::digit_char(top);
    assign o_rsp.last  = (r_left == CW'(1));

    // sequencer
    always_comb begin
        n_state = r_state;
        n_dig   = r_dig;
        n_bin   = r_bin;
        n_bits  = r_bits;
        n_left  = r_left;
        n_lead  = r_lead;
        unique case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_lead = 1'b1;
                    n_left = CW'(DIGITS);
                    if (i_req.hex) begin
                        n_dig   = DW'(i_req.mag);
                        n_state = C_EMIT;
                    end else begin
                        n_dig   = '0;
                        n_bin   = i_req.mag;
                        n_bits  = BW'(fsip_pkg::ARG_WIDTH);
                        n_state = C_DAB;
                    end
                end
            end
            C_DAB: begin
                n_dig  = {adj[DW-2:0], r_bin[fsip_pkg::ARG_WIDTH-1]};
                n_bin  = {r_bin[fsip_pkg::ARG_WIDTH-2:0], 1'b0};
                n_bits = r_bits - BW'(1);
                if (r_bits == BW'(1)) begin
                    n_state = C_EMIT;
                end
            end
            C_EMIT: begin
                if (skip) begin
                    n_dig  = {r_dig[DW-5:0], 4'h0};
                    n_left = r_left - CW'(1);
                end else if (i_take) begin
                    n_dig  = {r_dig[DW-5:0], 4'h0};
                    n_left = r_left - CW'(1);
                    n_lead = 1'b0;
                    if (r_left == CW'(1)) begin
                        n_state = C_IDLE;
                    end
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_bin  <= n_bin;
        r_bits <= n_bits;
        r_left <= n_left;
        r_lead <= n_lead;
    end

endmodule

FILE: rtl/core/format_string_integer_printer_top.sv
// top level of the format string integer printer
`timescale 1ns / 1ps

// Takes one format byte per input beat with its argument and emits printed
// characters tagged with the current text color; last_of_run marks the final
// character printed for an input beat; beats such as NUL, %o and %s print
// none. Input is taken only while the block is idle. For %d a minus sign
// goes out while the digits are still being formed: the converter shifts
// one argument bit per cycle through a double-dabble digit register, then
// moves one digit position per cycle, leading zeros included; a printed
// digit waits while the output is stalled. The user must write base_color
// only while the block is idle; the block itself does not enforce it. A
// new base_color takes effect at the next NUL; reset sets it back to
// BASE_COLOR_RESET.
module format_string_integer_printer_top #(
    parameter int DIGIT_STORE_DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  fsip_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output fsip_pkg::t_out_item o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic [fsip_pkg::COLOR_WIDTH-1:0] i_cfg_data,
    output logic                o_cfg_ready
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PAIR = 4'b0010,
        S_ONE  = 4'b0100,
        S_CONV = 4'b1000
    } t_state;

    t_state                              r_state, n_state;
    logic                                r_pct, n_pct;
    logic [fsip_pkg::COLOR_WIDTH-1:0]    r_base;
    logic [fsip_pkg::COLOR_WIDTH-1:0]    r_color, n_color;
    logic [fsip_pkg::CHAR_WIDTH-1:0]     r_c0, n_c0;
    logic [fsip_pkg::CHAR_WIDTH-1:0]     r_c1, n_c1;
    logic                                r_pair_conv, n_pair_conv;
    logic                                r_out_valid, n_out_valid;
    fsip_pkg::t_out_item                 r_out, n_out;
    fsip_pkg::t_conv_req                 conv_req;
    fsip_pkg::t_conv_rsp                 conv_rsp;
    logic                                in_acc;
    logic                                slot_free;
    logic                                conv_take;
    logic [fsip_pkg::CHAR_WIDTH-1:0]     ch;
    logic [fsip_pkg::ARG_WIDTH-1:0]      arg;
    logic                                arg_neg;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign slot_free   = !r_out_valid || !i_out_stall;
    assign conv_take   = (r_state == S_CONV) && slot_free;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign ch      = i_in_data.fmt_char;
    assign arg     = i_in_data.arg_value;
    assign arg_neg = arg[fsip_pkg::ARG_WIDTH-1];

    // converter request at accept time
    always_comb begin
        conv_req.start = in_acc && r_pct &&
                         ((ch == fsip_pkg::CH_CONV_D) || (ch == fsip_pkg::CH_CONV_X));
        conv_req.hex   = (ch == fsip_pkg::CH_CONV_X);
        if ((ch == fsip_pkg::CH_CONV_D) && arg_neg) begin
            conv_req.mag = '0 - arg;
        end else begin
            conv_req.mag = arg;
        end
    end

    fsip_conv #(
        .DIGITS (DIGIT_STORE_DEPTH)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (conv_req),
        .i_take  (conv_take),
        .o_rsp   (conv_rsp)
    );

    // format decode and emit sequencing
    always_comb begin
        n_state     = r_state;
        n_pct       = r_pct;
        n_color     = r_color;
        n_c0        = r_c0;
        n_c1        = r_c1;
        n_pair_conv = r_pair_conv;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (ch == fsip_pkg::CH_NUL) begin
                        n_pct   = 1'b0;
                        n_color = r_base;
                    end else if (!r_pct) begin
                        if (ch == fsip_pkg::CH_PCT) begin
                            n_pct = 1'b1;
                        end else begin
                            n_c1    = ch;
                            n_state = S_ONE;
                        end
                    end else begin
                        n_pct = 1'b0;
                        priority if (ch == fsip_pkg::CH_CONV_C) begin
                            n_c1    = arg[fsip_pkg::CHAR_WIDTH-1:0];
                            n_state = S_ONE;
                        end else if (ch == fsip_pkg::CH_CONV_D) begin
                            if (arg_neg) begin
                                n_c0        = fsip_pkg::CH_MINUS;
                                n_pair_conv = 1'b1;
                                n_state     = S_PAIR;
                            end else begin
                                n_state = S_CONV;
                            end
                        end else if (ch == fsip_pkg::CH_CONV_X) begin
                            n_state = S_CONV;
                        end else if (ch == fsip_pkg::CH_CONV_O) begin
                            n_color = (r_color & fsip_pkg::COLOR_HI_MASK) |
                                      {4'h0, arg[3:0]};
                        end else if (ch == fsip_pkg::CH_CONV_S) begin
                            n_state = S_IDLE;
                        end else if (ch == fsip_pkg::CH_PCT) begin
                            n_c1    = fsip_pkg::CH_PCT;
                            n_state = S_ONE;
                        end else begin
                            n_c0        = fsip_pkg::CH_PCT;
                            n_c1        = ch;
                            n_pair_conv = 1'b0;
                            n_state     = S_PAIR;
                        end
                    end
                end
            end
            S_PAIR: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_char: r_c0, text_color: r_color, last_of_run: 1'b0};
                    n_state     = r_pair_conv ? S_CONV : S_ONE;
                end
            end
            S_ONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_char: r_c1, text_color: r_color, last_of_run: 1'b1};
                    n_state     = S_IDLE;
                end
            end
            S_CONV: begin
                if (conv_take && conv_rsp.valid) begin
                    n_out_valid = 1'b1;
                    n_out       = '{out_char: conv_rsp.ch, text_color: r_color,
                                    last_of_run: conv_rsp.last};
                    if (conv_rsp.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pct       <= 1'b0;
            r_base      <= fsip_pkg::BASE_COLOR_RESET;
            r_color     <= fsip_pkg::BASE_COLOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pct       <= n_pct;
            r_color     <= n_color;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_c0        <= n_c0;
        r_c1        <= n_c1;
        r_pair_conv <= n_pair_conv;
        r_out       <= n_out;
    end

endmodule
